// ----- hdl/mtp_pkg.sv -----
`timescale 1ns / 1ps
package mtp_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SPEED_W        = 16;
    localparam int DT_W           = 16;
    localparam int MODE_W         = 2;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    typedef enum logic [2:0] {
        REG_TARGET_X   = 3'd0,
        REG_TARGET_Y   = 3'd1,
        REG_TARGET_Z   = 3'd2,
        REG_MOVE_SPEED = 3'd3,
        REG_NEXT_MODE  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        MOP_NONE = 3'd0,
        MOP_STEP = 3'd1,
        MOP_LIM  = 3'd2,
        MOP_SQX  = 3'd3,
        MOP_SQY  = 3'd4,
        MOP_SQZ  = 3'd5,
        MOP_PRD  = 3'd6
    } mop_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic  take;
        mop_t  mop;
        logic  sqrt_init;
        logic  sqrt_step;
        logic  div_step;
        logic  apply;
        logic  snap;
        axis_t axis;
    } dp_cmd_t;

    typedef struct packed {
        logic moving;
    } dp_status_t;

endpackage

// ----- hdl/mtp_ctrl.sv -----
`timescale 1ns / 1ps
module mtp_ctrl #(
    parameter int COORD_BITS = mtp_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_tick,
    output logic                 in_ready,
    input  logic                 out_free,
    output logic                 out_load,
    input  mtp_pkg::dp_status_t  status,
    output mtp_pkg::dp_cmd_t     cmd
);
    import mtp_pkg::*;

    localparam int NW   = COORD_BITS + 17;
    localparam int CNTW = $clog2(NW + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MULS   = 9'b000000010,
        ST_DECIDE = 9'b000000100,
        ST_SQRT   = 9'b000001000,
        ST_PROD   = 9'b000010000,
        ST_DIV    = 9'b000100000,
        ST_APPLY  = 9'b001000000,
        ST_DONE   = 9'b010000000,
        ST_SPARE  = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    axis_t            axis_reg, axis_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        axis_next     = axis_reg;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        cmd           = '0;
        cmd.mop       = MOP_NONE;
        cmd.axis      = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    cnt_next   = '0;
                    state_next = in_tick ? ST_MULS : ST_DONE;
                end
            end
            ST_MULS:
            begin
                unique case (cnt_reg)
                    CNTW'(0): cmd.mop = MOP_STEP;
                    CNTW'(1): cmd.mop = MOP_SQX;
                    CNTW'(2): cmd.mop = MOP_LIM;
                    CNTW'(3): cmd.mop = MOP_SQY;
                    CNTW'(4): cmd.mop = MOP_SQZ;
                    default:  cmd.mop = MOP_NONE;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(5))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
                if (status.moving)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_SQRT;
                end
                else
                begin
                    cmd.snap   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(COORD_BITS))
                begin
                    cnt_next   = '0;
                    axis_next  = AXIS_X;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                if (cnt_reg == CNTW'(0))
                    cmd.mop = MOP_PRD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1))
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                cnt_next  = '0;
                if (axis_reg == AXIS_Z)
                    state_next = ST_DONE;
                else
                begin
                    axis_next  = (axis_reg == AXIS_X) ? AXIS_Y : AXIS_Z;
                    state_next = ST_PROD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// ----- hdl/mtp_dp.sv -----
`timescale 1ns / 1ps
module mtp_dp #(
    parameter int COORD_BITS = mtp_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtp_pkg::dp_cmd_t                    cmd,
    output mtp_pkg::dp_status_t                 status,
    input  logic                                req_type,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        start_z,
    input  logic [mtp_pkg::DT_W-1:0]            delta_time,
    input  logic signed [COORD_BITS-1:0]        target_x,
    input  logic signed [COORD_BITS-1:0]        target_y,
    input  logic signed [COORD_BITS-1:0]        target_z,
    input  logic [mtp_pkg::SPEED_W-1:0]         move_speed,
    output logic signed [COORD_BITS-1:0]        pos_x,
    output logic signed [COORD_BITS-1:0]        pos_y,
    output logic signed [COORD_BITS-1:0]        pos_z,
    output logic                                arrived
);
    import mtp_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int MAGW = N + 1;
    localparam int OPW  = (MAGW > 32) ? MAGW : 32;
    localparam int PW   = 2 * OPW;
    localparam int SW   = 2 * N + 2;
    localparam int CMPW = (SW > 32) ? SW : 32;
    localparam int RMW  = N + 2;
    localparam int NW   = N + 17;

    logic signed [N-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic                arrived_reg;
    logic [DT_W-1:0]     dt_reg;
    logic [MAGW-1:0]     mag_x_reg, mag_y_reg, mag_z_reg;
    logic                neg_x_reg, neg_y_reg, neg_z_reg;
    logic [PW-1:0]       mul_reg;
    mop_t                tag_reg;
    logic [31:0]         s_reg;
    logic [31:0]         lim_reg;
    logic [SW-1:0]       sum_reg;
    logic [SW-1:0]       sqv_reg;
    logic [RMW-1:0]      rem_reg;
    logic [N:0]          root_reg;
    logic [NW-1:0]       dq_reg;
    logic [N:0]          drem_reg;

    logic signed [N:0]   dx, dy, dz;
    logic [OPW-1:0]      opa, opb;
    logic [MAGW-1:0]     mag_sel;
    logic [RMW+1:0]      rem2, trial;
    logic                sq_ge;
    logic [N+1:0]        r2;
    logic                dv_ge;
    logic signed [N:0]   step_q, cur_sel, cur_new;
    logic                neg_sel;

    assign dx = (N+1)'(target_x) - (N+1)'(cur_x_reg);
    assign dy = (N+1)'(target_y) - (N+1)'(cur_y_reg);
    assign dz = (N+1)'(target_z) - (N+1)'(cur_z_reg);

    always_comb
    begin
        unique case (cmd.axis)
            AXIS_X:
            begin
                mag_sel = mag_x_reg;
                neg_sel = neg_x_reg;
                cur_sel = (N+1)'(cur_x_reg);
            end
            AXIS_Y:
            begin
                mag_sel = mag_y_reg;
                neg_sel = neg_y_reg;
                cur_sel = (N+1)'(cur_y_reg);
            end
            default:
            begin
                mag_sel = mag_z_reg;
                neg_sel = neg_z_reg;
                cur_sel = (N+1)'(cur_z_reg);
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.mop)
            MOP_STEP:
            begin
                opa = OPW'(move_speed);
                opb = OPW'(dt_reg);
            end
            MOP_LIM:
            begin
                opa = OPW'(s_reg);
                opb = OPW'(s_reg);
            end
            MOP_SQX:
            begin
                opa = OPW'(mag_x_reg);
                opb = OPW'(mag_x_reg);
            end
            MOP_SQY:
            begin
                opa = OPW'(mag_y_reg);
                opb = OPW'(mag_y_reg);
            end
            MOP_SQZ:
            begin
                opa = OPW'(mag_z_reg);
                opb = OPW'(mag_z_reg);
            end
            MOP_PRD:
            begin
                opa = OPW'(mag_sel);
                opb = OPW'(s_reg);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign status.moving = CMPW'(sum_reg) > CMPW'(lim_reg);

    // one root digit per step
    assign rem2  = {rem_reg, sqv_reg[SW-1 -: 2]};
    assign trial = (RMW+2)'({root_reg, 2'b01});
    assign sq_ge = rem2 >= trial;

    // one quotient bit per step
    assign r2    = {drem_reg, dq_reg[NW-1]};
    assign dv_ge = r2 >= (N+2)'(root_reg);

    assign step_q  = signed'(dq_reg[N:0]);
    assign cur_new = neg_sel ? (cur_sel - step_q) : (cur_sel + step_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cur_z_reg   <= '0;
            arrived_reg <= 1'b0;
            tag_reg     <= MOP_NONE;
        end
        else
        begin
            tag_reg <= cmd.mop;
            if (cmd.take)
            begin
                arrived_reg <= 1'b0;
                if (!req_type)
                begin
                    cur_x_reg <= start_x;
                    cur_y_reg <= start_y;
                    cur_z_reg <= start_z;
                end
            end
            if (cmd.snap)
            begin
                cur_x_reg   <= target_x;
                cur_y_reg   <= target_y;
                cur_z_reg   <= target_z;
                arrived_reg <= 1'b1;
            end
            if (cmd.apply)
            begin
                unique case (cmd.axis)
                    AXIS_X:  cur_x_reg <= cur_new[N-1:0];
                    AXIS_Y:  cur_y_reg <= cur_new[N-1:0];
                    default: cur_z_reg <= cur_new[N-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= opa * opb;
        if (cmd.take)
        begin
            dt_reg    <= delta_time;
            neg_x_reg <= dx[N];
            neg_y_reg <= dy[N];
            neg_z_reg <= dz[N];
            mag_x_reg <= dx[N] ? MAGW'(-dx) : MAGW'(dx);
            mag_y_reg <= dy[N] ? MAGW'(-dy) : MAGW'(dy);
            mag_z_reg <= dz[N] ? MAGW'(-dz) : MAGW'(dz);
        end
        unique case (tag_reg)
            MOP_STEP: s_reg   <= mul_reg[31:0];
            MOP_LIM:  lim_reg <= mul_reg[63:32];
            MOP_SQX:  sum_reg <= mul_reg[SW-1:0];
            MOP_SQY,
            MOP_SQZ:  sum_reg <= sum_reg + mul_reg[SW-1:0];
            MOP_PRD:
            begin
                dq_reg   <= mul_reg[16 +: NW];
                drem_reg <= '0;
            end
            default: ;
        endcase
        if (cmd.sqrt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            sqv_reg  <= sum_reg;
        end
        if (cmd.sqrt_step)
        begin
            rem_reg  <= sq_ge ? RMW'(rem2 - trial) : RMW'(rem2);
            root_reg <= {root_reg[N-1:0], sq_ge};
            sqv_reg  <= {sqv_reg[SW-3:0], 2'b00};
        end
        if (cmd.div_step)
        begin
            drem_reg <= dv_ge ? (N+1)'(r2 - (N+2)'(root_reg)) : (N+1)'(r2);
            dq_reg   <= {dq_reg[NW-2:0], dv_ge};
        end
    end

    assign pos_x   = cur_x_reg;
    assign pos_y   = cur_y_reg;
    assign pos_z   = cur_z_reg;
    assign arrived = arrived_reg;

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> root_reg != '0)
        else $error("division by zero distance");
    a_snap_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.snap |=> (cur_x_reg == $past(target_x)) && (cur_y_reg == $past(target_y))
                     && (cur_z_reg == $past(target_z)) && arrived_reg)
        else $error("snap did not reach target");
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !req_type) |=> !arrived_reg && (cur_x_reg == $past(start_x)))
        else $error("load request left arrival set");
`endif

endmodule

// ----- hdl/move_toward_point_3d.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        tdata: start_x, start_y, start_z, delta_time;
//                                           tuser: req_type
// m_*       out  m_tvalid / m_tready        tdata: pos_x, pos_y, pos_z, mode_out;
//                                           tuser: arrived
// apb       in   psel, penable, pwrite      target_x/y/z, move_speed, next_mode
//
// a load request is accepted, passes through ST_DONE and is loaded into the result register once m_* is free
// a tick runs the bit-serial square root and three one-bit-a-cycle divisions,
// unless the step reaches the target, in which case the position snaps there
// one request in flight; the next is taken while the last result waits in m_*
// rst_n clears position, registers and handshake state at once
module move_toward_point_3d #(
    parameter int COORD_BITS = mtp_pkg::COORD_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // start_x, start_y, start_z, delta_time
    input  logic [((3*COORD_BITS+mtp_pkg::DT_W+7)/8)*8-1:0]   s_tdata,
    // req_type
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // pos_x, pos_y, pos_z, mode_out
    output logic [((3*COORD_BITS+mtp_pkg::MODE_W+7)/8)*8-1:0] m_tdata,
    // arrived
    output logic                                    m_tuser,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [mtp_pkg::APB_AW-1:0]              paddr,
    input  logic [mtp_pkg::APB_DW-1:0]              pwdata,
    output logic [mtp_pkg::APB_DW-1:0]              prdata,
    output logic                                    pready
);
    import mtp_pkg::*;

    localparam int N      = COORD_BITS;
    localparam int OUT_W  = 3 * N + MODE_W;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

    logic signed [N-1:0]  target_x_reg, target_y_reg, target_z_reg;
    logic [SPEED_W-1:0]   move_speed_reg;
    logic [MODE_W-1:0]    next_mode_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;
    logic                 m_user_reg;

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic                 out_free, out_load;
    logic signed [N-1:0]  pos_x, pos_y, pos_z;
    logic                 arrived;
    logic                 wr_en;
    reg_idx_t             idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            target_z_reg   <= '0;
            move_speed_reg <= '0;
            next_mode_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TARGET_X:   target_x_reg   <= pwdata[N-1:0];
                REG_TARGET_Y:   target_y_reg   <= pwdata[N-1:0];
                REG_TARGET_Z:   target_z_reg   <= pwdata[N-1:0];
                REG_MOVE_SPEED: move_speed_reg <= pwdata[SPEED_W-1:0];
                REG_NEXT_MODE:  next_mode_reg  <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET_X:   prdata = {{(APB_DW-N){target_x_reg[N-1]}}, target_x_reg};
            REG_TARGET_Y:   prdata = {{(APB_DW-N){target_y_reg[N-1]}}, target_y_reg};
            REG_TARGET_Z:   prdata = {{(APB_DW-N){target_z_reg[N-1]}}, target_z_reg};
            REG_MOVE_SPEED: prdata = APB_DW'(move_speed_reg);
            REG_NEXT_MODE:  prdata = APB_DW'(next_mode_reg);
            default:        prdata = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    mtp_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_tick  (s_tuser),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    mtp_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (s_tuser),
        .start_x    (s_tdata[0 +: N]),
        .start_y    (s_tdata[N +: N]),
        .start_z    (s_tdata[2*N +: N]),
        .delta_time (s_tdata[3*N +: DT_W]),
        .target_x   (target_x_reg),
        .target_y   (target_y_reg),
        .target_z   (target_z_reg),
        .move_speed (move_speed_reg),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .arrived    (arrived)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {(arrived ? next_mode_reg : MODE_W'(0)), pos_z, pos_y, pos_x};
            m_user_reg <= arrived;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DW'(m_data_reg);
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before taken");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && out_free) |=> out_load)
        else $error("load request result delayed");
`endif

endmodule
